[rtl/core/fpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared mode codes, the request and response word types and the classified word type.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int DATA_W = 32;
   localparam int MODE_W = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD = 4'd0,
      MODE_SUB = 4'd1,
      MODE_MUL = 4'd2,
      MODE_DIV = 4'd3,
      MODE_MIN = 4'd4,
      MODE_MAX = 4'd5,
      MODE_INC = 4'd6,
      MODE_DEC = 4'd7,
      MODE_I2F = 4'd8,
      MODE_F2I = 4'd9
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     div_zero;
      logic                     a_less;
      logic                     a_equal;
      logic                     a_greater;
   } rsp_type;

   // Classified word passed from the front part to the back part.
   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] operand_a;
      logic signed [DATA_W-1:0] operand_b;
      logic                     is_div;
      logic                     div_zero;
      logic                     a_less;
      logic                     a_equal;
      logic                     a_greater;
   } item_type;

endpackage

[rtl/core/fpa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU channel interfaces
// Valid and ready handshake channels for request and response words.
// ----------------------------------------------------------------------------
interface fpa_req_if import fpa_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/fpa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU front part
// Accepts request words, computes the comparison flags and pushes
// classified words into a small queue for the back part.
// ----------------------------------------------------------------------------
module fpa_front
   import fpa_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_word,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   item_type           cls;
   logic               push, pop;

   always_comb begin
      cls.mode      = in_word.mode;
      cls.operand_a = in_word.operand_a;
      cls.operand_b = in_word.operand_b;
      cls.is_div    = (in_word.mode == MODE_DIV);
      cls.div_zero  = (in_word.mode == MODE_DIV) && (in_word.operand_b == '0);
      cls.a_less    = in_word.operand_a < in_word.operand_b;
      cls.a_equal   = in_word.operand_a == in_word.operand_b;
      cls.a_greater = in_word.operand_a > in_word.operand_b;
   end

   assign in_ready  = (cnt_ff != (PTR_W+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_word  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= cls;
      end
   end

endmodule

[rtl/core/fpa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU divider
// Pipelined restoring divider on magnitudes, one quotient bit per stage,
// with a sideband word that travels alongside. Stalls as a whole.
// ----------------------------------------------------------------------------
module fpa_div
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = 8,
   parameter int SIDE_W    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic signed [DATA_W-1:0] dividend,
   input  logic signed [DATA_W-1:0] divisor,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DATA_W-1:0] quotient,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NUM_W = DATA_W + FRAC_BITS;

   logic              vld_ff  [NUM_W+1];
   logic [NUM_W-1:0]  num_ff  [NUM_W+1];
   logic [DATA_W-1:0] den_ff  [NUM_W+1];
   logic [DATA_W:0]   rem_ff  [NUM_W+1];
   logic              neg_ff  [NUM_W+1];
   logic [SIDE_W-1:0] side_ff [NUM_W+1];
   logic [NUM_W-1:0]  num_abs;
   logic [DATA_W-1:0] den_abs;
   logic [NUM_W-1:0]  num_ext;

   assign num_ext = {{FRAC_BITS{dividend[DATA_W-1]}}, dividend} << FRAC_BITS;
   assign num_abs = num_ext[NUM_W-1] ? (~num_ext + 1'b1) : num_ext;
   assign den_abs = divisor[DATA_W-1] ? DATA_W'(~divisor + 1'b1) : DATA_W'(divisor);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
      end
      if (enable) begin
         num_ff[0]  <= num_abs;
         den_ff[0]  <= den_abs;
         rem_ff[0]  <= '0;
         neg_ff[0]  <= num_ext[NUM_W-1] ^ divisor[DATA_W-1];
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DATA_W:0] trial;
      logic [DATA_W:0] diff;
      assign trial = {rem_ff[s][DATA_W-1:0], num_ff[s][NUM_W-1]};
      assign diff  = trial - {1'b0, den_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (enable) begin
            rem_ff[s+1]  <= diff[DATA_W] ? trial : diff;
            num_ff[s+1]  <= {num_ff[s][NUM_W-2:0], ~diff[DATA_W]};
            den_ff[s+1]  <= den_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];
   assign quotient  = neg_ff[NUM_W] ? DATA_W'(~num_ff[NUM_W] + 1'b1)
                                    : num_ff[NUM_W][DATA_W-1:0];

endmodule

[rtl/core/fpa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU back part
// Carries out classified words in a fixed-length pipeline: a first stage
// that registers the product and the other results, a divider, and an output
// register. All operations take the same latency so words leave in order.
// ----------------------------------------------------------------------------
module fpa_back
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_word,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_word
);

   localparam int SIDE_W = $bits(rsp_type);

   rsp_type                  pre;
   logic signed [2*DATA_W-1:0] prod;
   logic                     enable;
   logic                     pipe_valid;
   logic [DATA_W-1:0]        quo;
   logic [SIDE_W-1:0]        side_out;
   logic [SIDE_W+1:0]        side_in;
   rsp_type                  res;
   logic                     div_sel, mul_sel;
   logic                     mvld_ff;
   logic                     mdiv_ff, mmul_ff;
   rsp_type                  mres_ff;
   logic signed [2*DATA_W-1:0] mprod_ff;
   item_type                 mitem_ff;
   logic                     ovld_ff, ovld_in;
   rsp_type                  obuf_ff;
   rsp_type                  stg_res;

   assign prod = (2*DATA_W)'(in_word.operand_a) * (2*DATA_W)'(in_word.operand_b);

   always_comb begin
      pre.div_zero  = in_word.div_zero;
      pre.a_less    = in_word.a_less;
      pre.a_equal   = in_word.a_equal;
      pre.a_greater = in_word.a_greater;
      case (in_word.mode)
         MODE_ADD: pre.value = in_word.operand_a + in_word.operand_b;
         MODE_SUB: pre.value = in_word.operand_a - in_word.operand_b;
         MODE_MIN: pre.value = in_word.a_less ? in_word.operand_a : in_word.operand_b;
         MODE_MAX: pre.value = in_word.a_greater ? in_word.operand_a : in_word.operand_b;
         MODE_INC: pre.value = in_word.operand_a + 1'b1;
         MODE_DEC: pre.value = in_word.operand_a - 1'b1;
         MODE_I2F: pre.value = in_word.operand_a <<< FRAC_BITS;
         MODE_F2I: pre.value = in_word.operand_a >>> FRAC_BITS;
         default:  pre.value = '0;
      endcase
   end

   // Stage one registers the product; the divider consumes the word.
   assign enable   = !ovld_ff || out_ready;
   assign in_ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= 1'b0;
      end else if (enable) begin
         mvld_ff <= in_valid;
      end
      if (enable) begin
         mres_ff  <= pre;
         mprod_ff <= prod;
         mdiv_ff  <= in_word.is_div && !in_word.div_zero;
         mmul_ff  <= (in_word.mode == MODE_MUL);
         mitem_ff <= in_word;
      end
   end

   always_comb begin
      stg_res = mres_ff;
      if (mmul_ff) begin
         stg_res.value = DATA_W'(mprod_ff >>> FRAC_BITS);
      end
   end

   assign side_in = {mdiv_ff, 1'b0, stg_res};

   fpa_div #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE_W + 2)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (mvld_ff),
      .dividend  (mitem_ff.operand_a),
      .divisor   (mitem_ff.operand_b),
      .in_side   (side_in),
      .out_valid (pipe_valid),
      .quotient  (quo),
      .out_side  ({div_sel, mul_sel, side_out})
   );

   always_comb begin
      res = rsp_type'(side_out);
      if (div_sel && !mul_sel) begin
         res.value = quo;
      end
   end

   always_comb begin
      ovld_in = ovld_ff;
      if (enable) begin
         ovld_in = pipe_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else begin
         ovld_ff <= ovld_in;
      end
      if (enable) begin
         obuf_ff <= res;
      end
   end

   assign out_valid = ovld_ff;
   assign out_word  = obuf_ff;

endmodule

[rtl/core/fixed_point_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit fixed-point ALU with a queued front and a pipelined back.
// ----------------------------------------------------------------------------
// Throughput is one word per cycle while the response side does not stall; the divider pipeline sets the latency.
// Synchronous reset empties the queue and all pipeline stages.
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input logic          clock,
   input logic          reset,
   fpa_req_if.sink      req,
   fpa_rsp_if.source    rsp
);

   logic     q_valid, q_ready;
   item_type q_word;

   fpa_front #(
      .DEPTH (4)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_word   (req.payload),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_word  (q_word)
   );

   fpa_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_word   (q_word),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_word  (rsp.payload)
   );

endmodule

[rtl/core/fpa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker
   import fpa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_payload.a_less, rsp_payload.a_equal,
                             rsp_payload.a_greater}))
      else $error("comparison flags not one-hot");

   a_dz_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.div_zero |-> rsp_payload.value == '0)
      else $error("divide by zero with nonzero value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response word changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
